// ===== design/assert_macros.svh =====
// Assertion helpers shared by the encoder modules.
// Each use expands to one labeled concurrent assertion on clk,
// switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge of clk outside reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error(msg);

// Check that a condition never holds at a rising edge of clk outside reset.
`define ASSERT_NEVER(name, cond, msg) \
	`ASSERT_CLK(name, !(cond), msg)

`endif

// ===== design/abe_pkg.sv =====
// ----------------------------------------------------------------------------
// abe_pkg
// Shared constants, controller states and the command/status bundles
// between the encoder controller and its datapath.
// ----------------------------------------------------------------------------
package abe_pkg;

	// Default parameter values
	localparam int GUARD_BITS_DEF = 8;
	localparam int MAX_PREC_DEF   = 16;

	// Precision after reset, before clamping to the configured maximum
	localparam int PREC_RESET = 16;

	// Field widths
	localparam int CUM_W  = 17;
	localparam int PREC_W = 5;

	// Per-symbol limits: emitted bits kept, renormalization steps taken
	localparam int MAX_OUT    = 64;
	localparam int STEP_LIMIT = 256;
	localparam int OUT_CNT_W  = $clog2(MAX_OUT + 1);
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_CHECK,
		ST_RENORM,
		ST_LAST
	} abe_state_t;

	// Controller to datapath
	typedef struct packed {
		logic load;        // capture a symbol and clear per-symbol state
		logic set_finish;  // stage the final one bit, restart the interval
		logic set_err;     // stage an error result
		logic mul_lo;      // range times low bound
		logic mul_hi;      // form new start, range times width
		logic take_rg;     // form new range
		logic shift;       // emit top bit and double the interval
		logic split;       // keep the larger half of the interval
		logic commit;      // write the working interval back
		logic push_last;   // hand the staged bit out as the last beat
	} abe_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic in_finish;
		logic in_bad;
		logic rg_zero;
		logic can_shift;
		logic can_split;
		logic pend_valid;
		logic cnt_full;
		logic slot_free;
	} abe_sts_t;

endpackage

// ===== design/abe_if.sv =====
// ----------------------------------------------------------------------------
// abe_if
// Valid/ready channels of the encoder: symbol beats in, code bit beats out.
// ----------------------------------------------------------------------------
interface abe_sym_if;
	import abe_pkg::*;

	logic               valid;
	logic               ready;
	logic               cmd;
	logic [CUM_W-1:0]   cum_low;
	logic [CUM_W-1:0]   cum_high;

	modport source (output valid, output cmd, output cum_low, output cum_high, input ready);
	modport sink   (input valid, input cmd, input cum_low, input cum_high, output ready);
endinterface

interface abe_bit_if;
	logic valid;
	logic ready;
	logic out_bit;
	logic last;
	logic error;

	modport source (output valid, output out_bit, output last, output error, input ready);
	modport sink   (input valid, input out_bit, input last, input error, output ready);
endinterface

// ===== design/abe_ctrl.sv =====
// ----------------------------------------------------------------------------
// abe_ctrl
// Sequencer of the encoder: symbol intake, two multiply steps,
// the renormalization loop and the hand-off of the last beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abe_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              sym_valid,
	output logic              sym_ready,
	input  abe_pkg::abe_sts_t sts,
	output abe_pkg::abe_cmd_t cmd
);
	import abe_pkg::*;

	abe_state_t state_q;
	abe_state_t state_d;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sym_valid) begin
					if (sts.in_finish || sts.in_bad) begin
						state_d = ST_LAST;
					end else begin
						state_d = ST_MUL_LO;
					end
				end
			end
			ST_MUL_LO: begin
				state_d = ST_MUL_HI;
			end
			ST_MUL_HI: begin
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.rg_zero) begin
					state_d = ST_LAST;
				end else begin
					state_d = ST_RENORM;
				end
			end
			ST_RENORM: begin
				if (!sts.can_shift && !sts.can_split) begin
					if (sts.pend_valid) begin
						state_d = ST_LAST;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_LAST: begin
				if (sts.slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands
	always_comb begin
		cmd       = '0;
		sym_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sym_ready = 1'b1;
				if (sym_valid) begin
					cmd.load       = 1'b1;
					cmd.set_finish = sts.in_finish;
					cmd.set_err    = !sts.in_finish && sts.in_bad;
				end
			end
			ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
			end
			ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
			end
			ST_CHECK: begin
				if (sts.rg_zero) begin
					cmd.set_err = 1'b1;
				end else begin
					cmd.take_rg = 1'b1;
				end
			end
			ST_RENORM: begin
				// hold the shift while an earlier bit cannot leave
				if (sts.can_shift) begin
					cmd.shift = !(sts.pend_valid && !sts.cnt_full && !sts.slot_free);
				end else if (sts.can_split) begin
					cmd.split = 1'b1;
				end else begin
					cmd.commit = 1'b1;
				end
			end
			ST_LAST: begin
				cmd.push_last = sts.slot_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// The last beat always has a staged bit behind it
	`ASSERT_CLK(a_last_has_bit, (state_q == ST_LAST) |-> sts.pend_valid, "last beat without staged bit")
	// A symbol is only taken while the sequencer is free
	`ASSERT_CLK(a_load_idle, cmd.load |-> (state_q == ST_IDLE), "symbol taken while busy")

endmodule

// ===== design/abe_dp.sv =====
// ----------------------------------------------------------------------------
// abe_dp
// Encoder datapath: precision and interval registers, the shared
// multiplier, the one-step renormalization unit, the staged bit and
// the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module abe_dp #(
	parameter int GUARD_BITS    = abe_pkg::GUARD_BITS_DEF,
	parameter int MAX_PRECISION = abe_pkg::MAX_PREC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abe_pkg::PREC_W-1:0] cfg_wdata,
	input  logic                       sym_cmd,
	input  logic [abe_pkg::CUM_W-1:0]  cum_low,
	input  logic [abe_pkg::CUM_W-1:0]  cum_high,
	input  logic                       code_ready,
	output logic                       code_valid,
	output logic                       out_bit,
	output logic                       last,
	output logic                       error,
	input  abe_pkg::abe_cmd_t          cmd,
	output abe_pkg::abe_sts_t          sts
);
	import abe_pkg::*;

	// Interval width: holds twice the top-bit weight at the largest precision
	localparam int W    = MAX_PRECISION + GUARD_BITS + 2;
	localparam int SW   = $clog2(W);
	localparam int PRW  = $clog2(MAX_PRECISION + 1);
	localparam int LW   = MAX_PRECISION + 1;
	localparam int CW   = (LW > CUM_W) ? LW : CUM_W;
	localparam int PW   = W + LW;
	localparam int PREC_RST = (PREC_RESET > MAX_PRECISION) ? MAX_PRECISION : PREC_RESET;

	logic [PRW-1:0]       prec_q;
	logic [W-1:0]         start_q;
	logic [W-1:0]         range_q;
	logic [LW-1:0]        lo_q;
	logic [LW-1:0]        hi_q;
	logic [PW-1:0]        prod_q;
	logic [W-1:0]         st_q;
	logic [W-1:0]         rg_q;
	logic [STEP_W-1:0]    steps_q;
	logic [OUT_CNT_W-1:0] cnt_q;
	logic                 pend_valid_q;
	logic                 pend_bit_q;
	logic                 pend_err_q;
	logic                 out_valid_q;
	logic                 out_bit_q;
	logic                 out_last_q;
	logic                 out_err_q;

	logic [PRW-1:0] cfg_prec;
	logic [SW-1:0]  p_s;
	logic [SW-1:0]  s_s;
	logic [CW-1:0]  base_c;
	logic [CW-1:0]  lo_sat;
	logic [CW-1:0]  hi_sat;
	logic [LW-1:0]  mul_opnd;
	logic [PW-1:0]  prod_d;
	logic [PW-1:0]  prod_sh;
	logic [W-1:0]   scaled;
	logic [W-1:0]   top;
	logic [W-1:0]   base;
	logic [W-1:0]   low_mask;
	logic [W-1:0]   end_v;
	logic [W-1:0]   sum_v;
	logic [W-1:0]   left;
	logic [W-1:0]   right;
	logic           steps_ok;
	logic           cnt_full;
	logic           new_bit;
	logic           push_mid;
	logic           push;
	logic           slot_free;

	// Clamp the written precision to one up to the maximum
	always_comb begin
		if (cfg_wdata == '0) begin
			cfg_prec = PRW'(1);
		end else if (int'(cfg_wdata) > MAX_PRECISION) begin
			cfg_prec = PRW'(MAX_PRECISION);
		end else begin
			cfg_prec = PRW'(cfg_wdata);
		end
	end

	assign p_s = SW'(prec_q);
	assign s_s = p_s + SW'(GUARD_BITS);

	// Saturate the bounds at the probability base
	assign base_c = CW'(1) << prec_q;
	assign lo_sat = (CW'(cum_low) > base_c) ? base_c : CW'(cum_low);
	assign hi_sat = (CW'(cum_high) > base_c) ? base_c : CW'(cum_high);

	// Shared multiplier, scaled back by the precision
	assign mul_opnd = cmd.mul_lo ? lo_q : (hi_q - lo_q);
	assign prod_d   = PW'(range_q) * PW'(mul_opnd);
	assign prod_sh  = prod_q >> prec_q;
	assign scaled   = prod_sh[W-1:0];

	// Renormalization step on the working interval
	assign top      = W'(1) << s_s;
	assign base     = W'(1) << p_s;
	assign low_mask = top - W'(1);
	assign sum_v    = st_q + rg_q;
	assign end_v    = sum_v - W'(1);
	assign left     = top - st_q;
	assign right    = rg_q - left;
	assign new_bit  = |(st_q & top);
	assign steps_ok = steps_q < STEP_W'(STEP_LIMIT);
	assign cnt_full = cnt_q == OUT_CNT_W'(MAX_OUT);

	// Output slot
	assign slot_free = !out_valid_q || code_ready;
	assign push_mid  = cmd.shift && pend_valid_q && !cnt_full;
	assign push      = push_mid || cmd.push_last;

	// Status
	always_comb begin
		sts            = '0;
		sts.in_finish  = sym_cmd;
		sts.in_bad     = hi_sat <= lo_sat;
		sts.rg_zero    = scaled == '0;
		sts.can_shift  = steps_ok && ((st_q & ~low_mask) == (end_v & ~low_mask));
		sts.can_split  = steps_ok && (rg_q < base) && (st_q < top) && (sum_v > top);
		sts.pend_valid = pend_valid_q;
		sts.cnt_full   = cnt_full;
		sts.slot_free  = slot_free;
	end

	// Precision and committed interval
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prec_q  <= PRW'(PREC_RST);
			start_q <= '0;
			range_q <= W'(1) << (PREC_RST + GUARD_BITS + 1);
		end else if (cfg_we) begin
			prec_q  <= cfg_prec;
			start_q <= '0;
			range_q <= W'(1) << (SW'(cfg_prec) + SW'(GUARD_BITS + 1));
		end else if (cmd.set_finish) begin
			start_q <= '0;
			range_q <= W'(1) << (p_s + SW'(GUARD_BITS + 1));
		end else if (cmd.commit) begin
			start_q <= st_q;
			range_q <= rg_q;
		end
	end

	// Symbol bounds, product and working interval
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lo_q <= lo_sat[LW-1:0];
			hi_q <= hi_sat[LW-1:0];
		end
		if (cmd.mul_lo || cmd.mul_hi) begin
			prod_q <= prod_d;
		end
		if (cmd.mul_hi) begin
			st_q <= start_q + scaled;
		end else if (cmd.take_rg) begin
			rg_q <= scaled;
		end else if (cmd.shift) begin
			st_q <= (st_q & low_mask) << 1;
			rg_q <= rg_q << 1;
		end else if (cmd.split) begin
			if (left > right) begin
				rg_q <= left;
			end else begin
				st_q <= top;
				rg_q <= right;
			end
		end
	end

	// Step and bit counters, staged bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steps_q      <= '0;
			cnt_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				steps_q <= '0;
			end else if (cmd.shift || cmd.split) begin
				steps_q <= steps_q + STEP_W'(1);
			end
			if (cmd.load) begin
				cnt_q <= '0;
			end else if (cmd.shift && !cnt_full) begin
				cnt_q <= cnt_q + OUT_CNT_W'(1);
			end
			if (cmd.set_finish || cmd.set_err || (cmd.shift && !cnt_full)) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.push_last || cmd.load) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.set_finish) begin
			pend_bit_q <= 1'b1;
			pend_err_q <= 1'b0;
		end else if (cmd.set_err) begin
			pend_bit_q <= 1'b0;
			pend_err_q <= 1'b1;
		end else if (cmd.shift && !cnt_full) begin
			pend_bit_q <= new_bit;
			pend_err_q <= 1'b0;
		end
	end

	// Output register: load on a push, drop once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (push) begin
			out_valid_q <= 1'b1;
		end else if (code_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_bit_q  <= pend_bit_q;
			out_last_q <= cmd.push_last;
			out_err_q  <= cmd.push_last & pend_err_q;
		end
	end

	assign code_valid = out_valid_q;
	assign out_bit    = out_bit_q;
	assign last       = out_last_q;
	assign error      = out_err_q;

	// A beat is never written over one that is still waiting
	`ASSERT_NEVER(a_push_over, push && !slot_free, "output beat overwritten")
	// The loop never works on an empty interval
	`ASSERT_CLK(a_rg_live, (cmd.shift || cmd.split) |-> (rg_q != '0), "renorm on empty range")
	// Step counter stays within the loop bound
	`ASSERT_CLK(a_steps_bound, steps_q <= STEP_W'(STEP_LIMIT), "step counter overrun")

endmodule

// ===== design/arithmetic_bit_encoder.sv =====
// ----------------------------------------------------------------------------
// arithmetic_bit_encoder
// Integer arithmetic encoder with one code bit per output beat.
//
//   channel  dir  payload                     handshake
//   sym      in   cmd, cum_low, cum_high      valid / ready
//   code     out  out_bit, last, error        valid / ready
//   cfg      in   cfg_wdata (precision)       cfg_we
//
// Finish beats and symbols with empty bounds go straight to the last beat.
// A symbol runs two multiply steps, a range check and the renormalization
// loop (one shift or one split per cycle in the shared step unit unless the
// output holds a shift), then its last bit if any; zero range skips the loop.
// The two products of a symbol share one multiplier in back-to-back cycles.
// arst_n clears control state and sets precision 16 (capped) and its interval.
// A full output register holds the loop; a new symbol is taken once the
// previous one has staged its last beat.
// ----------------------------------------------------------------------------
module arithmetic_bit_encoder #(
	parameter int GUARD_BITS    = abe_pkg::GUARD_BITS_DEF,
	parameter int MAX_PRECISION = abe_pkg::MAX_PREC_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [abe_pkg::PREC_W-1:0] cfg_wdata,
	abe_sym_if.sink                    sym,
	abe_bit_if.source                  code
);
	import abe_pkg::*;

	abe_cmd_t cmd;
	abe_sts_t sts;

	// Sequencer
	abe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym.valid),
		.sym_ready (sym.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath
	abe_dp #(
		.GUARD_BITS    (GUARD_BITS),
		.MAX_PRECISION (MAX_PRECISION)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.sym_cmd    (sym.cmd),
		.cum_low    (sym.cum_low),
		.cum_high   (sym.cum_high),
		.code_ready (code.ready),
		.code_valid (code.valid),
		.out_bit    (code.out_bit),
		.last       (code.last),
		.error      (code.error),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for arithmetic_bit_encoder. Symbol beats go out from a
// queue through a clocked driver. Each accepted beat runs through a local
// model of the interval coder, and the model's code bits queue up in order.
// A clocked monitor compares every code beat with the oldest queued bit.
// The run covers several precision settings and both sides idling, plus
// one long output stall.
// ----------------------------------------------------------------------------
module testbench;
	import abe_pkg::*;

	localparam int GUARD         = GUARD_BITS_DEF;
	localparam int MAX_PREC      = MAX_PREC_DEF;
	localparam int SETTLE_CYCLES = 300;
	localparam int PHASE_ITEMS   = 13;
	localparam int STALL_CYCLES  = 400;

	localparam logic CMD_ENCODE = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef struct packed {
		logic             cmd;
		logic [CUM_W-1:0] cum_low;
		logic [CUM_W-1:0] cum_high;
	} sym_beat_t;

	typedef struct packed {
		logic out_bit;
		logic last;
		logic error;
	} code_beat_t;

	localparam code_beat_t FINISH_BEAT     = '{out_bit: 1'b1, last: 1'b1, error: 1'b0};
	localparam code_beat_t ZERO_WIDTH_BEAT = '{out_bit: 1'b0, last: 1'b1, error: 1'b1};

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [PREC_W-1:0] cfg_wdata;

	abe_sym_if sym ();
	abe_bit_if code ();

	arithmetic_bit_encoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.sym       (sym),
		.code      (code)
	);

	// Coder model state
	int unsigned prec;
	logic [24:0] ivl_start;
	logic [25:0] ivl_range;
	logic [63:0] work_start;
	logic [63:0] work_range;
	int          work_steps;
	logic        staged_bits[$];

	sym_beat_t   pending_syms[$];
	code_beat_t  expected_bits[$];

	int          src_idle_pct;
	int          snk_idle_pct;
	logic        hold_rx;
	logic        stall_go;
	int          stall_left;
	int          fail_count;

	// ------------------------------------------------------------------
	// Coder model
	// ------------------------------------------------------------------

	function automatic void restart_interval();
		ivl_start = '0;
		ivl_range = 26'(64'd1 << (prec + GUARD + 1));
	endfunction

	// Clamp the written precision and start a fresh stream
	function automatic void set_precision(logic [PREC_W-1:0] v);
		if (v < 1)
			prec = 1;
		else if (v > MAX_PREC)
			prec = MAX_PREC;
		else
			prec = 32'(v);
		restart_interval();
	endfunction

	// (a * b) >> prec without losing the high product bits
	function automatic logic [63:0] scale_by_prob(logic [63:0] a, logic [63:0] b);
		logic [63:0] mask;
		mask = (64'd1 << prec) - 64'd1;
		return ((a >> prec) * b) + (((a & mask) * b) >> prec);
	endfunction

	// Emit the top bit while both interval ends agree on it
	function automatic void shift_agreed_bits(int unsigned s);
		logic [63:0] top;
		top = 64'd1 << s;
		while (work_steps < STEP_LIMIT &&
				(work_start >> s) == ((work_start + work_range - 64'd1) >> s)) begin
			if (staged_bits.size() < MAX_OUT)
				staged_bits.insert(staged_bits.size(), work_start[s]);
			work_start = (work_start & (top - 64'd1)) << 1;
			work_range = work_range << 1;
			work_steps++;
		end
	endfunction

	// Advance the model by one accepted symbol beat
	function automatic void predict_beat(sym_beat_t b);
		int unsigned s;
		logic [63:0] top;
		logic [63:0] base;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] left;
		logic [63:0] right;
		s    = prec + GUARD;
		top  = 64'd1 << s;
		base = 64'd1 << prec;
		lo   = 64'(b.cum_low);
		hi   = 64'(b.cum_high);

		if (b.cmd == CMD_FINISH) begin
			expected_bits.insert(expected_bits.size(), FINISH_BEAT);
			restart_interval();
			return;
		end

		// saturate bounds to the base; empty symbol leaves the state alone
		if (lo > base)
			lo = base;
		if (hi > base)
			hi = base;
		if (hi <= lo) begin
			expected_bits.insert(expected_bits.size(), ZERO_WIDTH_BEAT);
			return;
		end

		work_start = 64'(ivl_start) + scale_by_prob(64'(ivl_range), lo);
		work_range = scale_by_prob(64'(ivl_range), hi - lo);
		if (work_range == 0) begin
			expected_bits.insert(expected_bits.size(), ZERO_WIDTH_BEAT);
			return;
		end

		work_steps = 0;
		staged_bits.delete();
		shift_agreed_bits(s);

		// range too narrow: keep the larger half around the top weight
		while (work_range < base && work_steps < STEP_LIMIT) begin
			if (work_start >= top || work_start + work_range <= top)
				break;
			left  = top - work_start;
			right = work_range - left;
			if (left > right) begin
				work_range = left;
			end else begin
				work_start = work_start + left;
				work_range = right;
			end
			work_steps++;
			shift_agreed_bits(s);
		end

		ivl_start = work_start[24:0];
		ivl_range = work_range[25:0];
		foreach (staged_bits[i])
			expected_bits.insert(expected_bits.size(), code_beat_t'{out_bit: staged_bits[i],
				last: (i == staged_bits.size() - 1), error: 1'b0});
	endfunction

	function automatic void check_field(string name, logic want, logic got);
		if (got !== want) begin
			$error("%s mismatch: expected %0b, actual %0b", name, want, got);
			fail_count++;
		end
	endfunction

	// ------------------------------------------------------------------
	// Clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Symbol driver: predict on accept, then offer the next beat or idle
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drive_sym
		sym_beat_t nxt;
		if (!arst_n) begin
			sym.valid    <= 1'b0;
			sym.cmd      <= CMD_ENCODE;
			sym.cum_low  <= '0;
			sym.cum_high <= '0;
		end else begin
			if (sym.valid && sym.ready)
				predict_beat(sym_beat_t'{sym.cmd, sym.cum_low, sym.cum_high});
			// hold a beat that is still waiting
			if (!sym.valid || sym.ready) begin
				if (pending_syms.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
					nxt = pending_syms.pop_front();
					sym.valid    <= 1'b1;
					sym.cmd      <= nxt.cmd;
					sym.cum_low  <= nxt.cum_low;
					sym.cum_high <= nxt.cum_high;
				end else begin
					sym.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Code monitor: compare each beat, then pick the next ready
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : watch_code
		code_beat_t want;
		if (!arst_n) begin
			code.ready <= 1'b0;
		end else begin
			if (code.valid && code.ready) begin
				if (expected_bits.size() == 0) begin
					$error("code beat with nothing expected: out_bit %0b last %0b error %0b",
						code.out_bit, code.last, code.error);
					fail_count++;
				end else begin
					want = expected_bits.pop_front();
					check_field("out_bit", want.out_bit, code.out_bit);
					check_field("last", want.last, code.last);
					check_field("error", want.error, code.error);
				end
			end
			code.ready <= !hold_rx && ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// ------------------------------------------------------------------
	// Output hold: count down a long stretch once asked
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : hold_code
		if (!arst_n) begin
			stall_left <= 0;
		end else if (stall_go) begin
			stall_left <= STALL_CYCLES;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end
	end

	assign hold_rx = (stall_left != 0);

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------

	task automatic queue_sym(logic cmd, int unsigned lo, int unsigned hi);
		pending_syms.insert(pending_syms.size(), sym_beat_t'{cmd, CUM_W'(lo), CUM_W'(hi)});
	endtask

	// Runs of well-formed symbols, mostly closed by a finish, some noise
	task automatic queue_streams(int count);
		int          made;
		int          run_len;
		int unsigned base;
		int unsigned lo;
		base = 1 << prec;
		made = 0;
		while (made < count) begin
			run_len = $urandom_range(1, 6);
			repeat (run_len) begin
				if ($urandom_range(0, 99) < 85) begin
					lo = $urandom_range(0, base - 1);
					queue_sym(CMD_ENCODE, lo, $urandom_range(lo + 1, base));
				end else begin
					queue_sym(CMD_ENCODE, $urandom_range(0, 17'h1FFFF),
						$urandom_range(0, 17'h1FFFF));
				end
				made++;
			end
			if ($urandom_range(0, 3) != 0) begin
				queue_sym(CMD_FINISH, $urandom_range(0, 17'h1FFFF), $urandom_range(0, 17'h1FFFF));
				made++;
			end
		end
	endtask

	// Wait for the queues to empty, then let the coder settle
	task automatic wait_drained();
		@(negedge clk);
		while (pending_syms.size() != 0 || sym.valid || expected_bits.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_precision(logic [PREC_W-1:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		set_precision(v);
		@(negedge clk);
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [PREC_W-1:0] setting;
		fail_count   = 0;
		src_idle_pct = 31;
		snk_idle_pct = 50;
		stall_go     = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		set_precision(PREC_W'(PREC_RESET));

		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed beats at the reset precision
		queue_sym(CMD_ENCODE, 0, 65536);           // full interval, no bits
		queue_sym(CMD_ENCODE, 0, 1);               // narrowest symbol, many bits
		queue_sym(CMD_ENCODE, 65535, 65536);
		queue_sym(CMD_ENCODE, 17'h1FFFF, 17'h1FFFF); // both saturate: empty
		queue_sym(CMD_ENCODE, 0, 17'h1FFFF);       // upper bound saturates
		queue_sym(CMD_ENCODE, 40000, 40000);       // equal bounds
		queue_sym(CMD_ENCODE, 50000, 20000);       // reversed bounds
		queue_sym(CMD_ENCODE, 32768, 32769);
		queue_sym(CMD_ENCODE, 21845, 43690);
		queue_sym(CMD_FINISH, 17'h1FFFF, 17'h1FFFF);
		queue_sym(CMD_FINISH, 0, 0);               // finish on a fresh interval
		queue_sym(CMD_ENCODE, 1, 2);
		queue_sym(CMD_ENCODE, 65536, 17'h1FFFF);   // both at base: empty
		queue_sym(CMD_ENCODE, 0, 65536);
		queue_sym(CMD_ENCODE, 1000, 1001);
		queue_sym(CMD_ENCODE, 64000, 64100);
		queue_sym(CMD_ENCODE, 65536, 65536);
		queue_sym(CMD_ENCODE, 0, 32768);
		queue_sym(CMD_FINISH, 0, 0);
		wait_drained();

		// Random phases, each after a precision write
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: setting = 5'd1;
				1: setting = 5'd0;   // clamps up to one
				2: setting = 5'd31;  // clamps down to the maximum
				3: setting = 5'd16;
				4: setting = 5'd4;
				5: setting = 5'd9;
				default: setting = PREC_W'($urandom_range(1, MAX_PREC));
			endcase
			if (ph < 2) begin
				src_idle_pct = 31;
				snk_idle_pct = 50;
			end else if (ph < 4) begin
				src_idle_pct = 50;
				snk_idle_pct = 31;
			end else begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end
			write_precision(setting);

			if (ph == 5) begin
				// stall the output while symbols keep coming
				@(posedge clk);
				stall_go <= 1'b1;
				@(posedge clk);
				stall_go <= 1'b0;
				queue_streams(PHASE_ITEMS);
			end else begin
				queue_streams(PHASE_ITEMS);
			end
			wait_drained();
		end

		if (fail_count == 0 && expected_bits.size() == 0)
			$display("arithmetic_bit_encoder verification clean");
		else
			$display("arithmetic_bit_encoder verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// Run limit
	// ------------------------------------------------------------------
	initial begin
		#20_000_000;
		$display("arithmetic_bit_encoder verification failed");
		$finish;
	end

endmodule
